// ===== hdl/radar_measurement_jacobian_core_defines.svh =====
// Assertion macros used by the core's RTL.
`ifndef RADAR_MEASUREMENT_JACOBIAN_CORE_DEFINES_SVH
`define RADAR_MEASUREMENT_JACOBIAN_CORE_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted.
`define RMJ_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, also checked across reset.
`define RMJ_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/rmj_pkg.sv =====
package rmj_pkg;

    localparam int          FRAC_BITS_DEF = 16;
    localparam logic [30:0] LIMIT_RESET   = 31'd7;
    localparam logic [31:0] MAG_CAP       = 32'h8000_0000;
    localparam logic [31:0] POS_MAX       = 32'h7FFF_FFFF;

    // Apply a sign to a magnitude and saturate to the signed 32-bit range.
    function automatic logic [31:0] sign_sat(input logic [31:0] mag, input logic neg);
        logic [31:0] res;
        if (neg) begin
            res = (mag >= MAG_CAP) ? MAG_CAP : (~mag + 32'd1);
        end else begin
            res = (mag >= MAG_CAP) ? POS_MAX : mag;
        end
        return res;
    endfunction

endpackage

// ===== hdl/radar_measurement_jacobian_core.sv =====
// Radar measurement Jacobian core.
// Each input item carries a position and velocity (pos_x, pos_y, vel_x, vel_y)
// in signed fixed point with FRAC_BITS fraction bits. Each item gives exactly
// one result item holding the six distinct Jacobian entries and range_zero.
// Both channels use valid and stall; an item moves on a rising edge where
// valid is high and stall is low. The single configuration register holds
// the squared-range threshold and is written whenever i_cfg_wr_en is high.
// The datapath is one pipeline of FRAC_BITS + 40 register stages: five
// front stages (input register, squares and cross products, sums, threshold
// test, recurrence seeds), 32 stages of the square-root recurrence,
// FRAC_BITS + 1 stages of restoring division by the range, and two multiply
// stages ending in the output register. The bearing and range-rate divisions
// run in parallel with the square root. One item is taken every cycle while
// o_stall is low.
// When the output register holds an item and i_stall is high, the whole
// pipeline freezes and o_stall is raised; nothing is lost or repeated.
// Reset clears every valid bit and sets the threshold to 7.
module radar_measurement_jacobian_core import rmj_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [30:0]        i_cfg_wr_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_dr_dx,
    output logic signed [31:0] o_dr_dy,
    output logic signed [31:0] o_dphi_dx,
    output logic signed [31:0] o_dphi_dy,
    output logic signed [31:0] o_drate_dx,
    output logic signed [31:0] o_drate_dy,
    output logic               o_range_zero
);

    `include "radar_measurement_jacobian_core_defines.svh"

    localparam int F     = FRAC_BITS;
    localparam int NS    = 32 + F + 1;   // root stages followed by divide stages
    localparam int VN    = 5 + NS + 2;   // total register stages
    localparam int ONE_Q = 1 << F;

    // Signs and magnitudes carried through the front stages.
    typedef struct packed {
        logic        sx;
        logic        sy;
        logic        pypos;
        logic [31:0] ax;
        logic [31:0] ay;
    } t_pre;

    // State of one item inside the iterative part of the pipeline.
    typedef struct packed {
        logic          zero;
        logic          sx;
        logic          sy;
        logic          pypos;
        logic          cneg;
        logic          ksat;
        logic [31:0]   ax;
        logic [31:0]   ay;
        logic [63:0]   d;
        logic [63:0]   cmag;
        logic [31:0]   root;
        logic [33:0]   srem;
        logic [31:0]   rx;
        logic [31:0]   ry;
        logic [F:0]    cx;
        logic [F:0]    cy;
        logic [63:0]   prx;
        logic [63:0]   pry;
        logic [2*F:0]  qpx;
        logic [2*F:0]  qpy;
        logic [63:0]   krem;
        logic [F+30:0] kq;
    } t_st;

    logic [30:0]        r_lim;
    logic [VN-1:0]      r_vld;
    logic               w_adv;

    logic signed [31:0] r_px, r_py, r_vx, r_vy;
    logic [31:0]        w_pxu, w_pyu;
    logic signed [63:0] w_sqx, w_sqy, w_t1, w_t2;
    t_pre               n_pre2;

    logic [63:0]        r_sqx, r_sqy;
    logic signed [63:0] r_t1, r_t2;
    t_pre               r_pre2;

    logic [63:0]        r_d3;
    logic signed [64:0] r_diff;
    t_pre               r_pre3;

    logic [63:0]        r_d4;
    logic [63:0]        r_cmag;
    logic               r_cneg;
    logic               r_zero;
    t_pre               r_pre4;
    logic [64:0]        w_negdiff;

    t_st                r_st [0:NS];
    t_st                n_st [0:NS-1];
    t_st                n_st0;

    logic [31:0]        r_m_drdx, r_m_drdy, r_m_dphix, r_m_dphiy;
    logic               r_m_zero;
    logic [31:0]        n_m_drdx, n_m_drdy, n_m_dphix, n_m_dphiy;
    logic [63:0]        w_qpx_ext, w_qpy_ext;
    logic [31:0]        w_magpx, w_magpy;

    logic [31:0]        r_o_drdx, r_o_drdy, r_o_dphix, r_o_dphiy;
    logic               r_o_zero;
    logic [31:0]        w_rate_x, w_rate_y;

    // The pipeline moves unless a finished item waits on a stalled receiver.
    assign w_adv   = !(r_vld[VN-1] && i_stall);
    assign o_stall = !w_adv;
    assign o_valid = r_vld[VN-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= LIMIT_RESET;
            r_vld <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_lim <= i_cfg_wr_data;
            end
            if (w_adv) begin
                r_vld <= {r_vld[VN-2:0], i_valid};
            end
        end
    end

    // Stage 1 registers the incoming item.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_px <= i_pos_x;
            r_py <= i_pos_y;
            r_vx <= i_vel_x;
            r_vy <= i_vel_y;
        end
    end

    // Stage 2: squares, cross products and magnitudes.
    always_comb begin
        w_pxu        = r_px;
        w_pyu        = r_py;
        w_sqx        = r_px * r_px;
        w_sqy        = r_py * r_py;
        w_t1         = r_vx * r_py;
        w_t2         = r_vy * r_px;
        n_pre2.sx    = r_px[31];
        n_pre2.sy    = r_py[31];
        n_pre2.pypos = !r_py[31] && (r_py != 32'sd0);
        n_pre2.ax    = r_px[31] ? (~w_pxu + 32'd1) : w_pxu;
        n_pre2.ay    = r_py[31] ? (~w_pyu + 32'd1) : w_pyu;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sqx  <= w_sqx;
            r_sqy  <= w_sqy;
            r_t1   <= w_t1;
            r_t2   <= w_t2;
            r_pre2 <= n_pre2;
        end
    end

    // Stage 3: squared range and the signed cross term.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d3   <= r_sqx + r_sqy;
            r_diff <= 65'(r_t1) - 65'(r_t2);
            r_pre3 <= r_pre2;
        end
    end

    // Stage 4: magnitude of the cross term and the near-zero test.
    assign w_negdiff = -r_diff;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d4   <= r_d3;
            r_cneg <= r_diff[64];
            r_cmag <= r_diff[64] ? w_negdiff[63:0] : r_diff[63:0];
            r_zero <= (r_d3 == 64'd0) || (r_d3 < (64'(r_lim) << F));
            r_pre4 <= r_pre3;
        end
    end

    // Stage 5 seeds the recurrences. The range-rate quotient saturates when
    // it would reach 2^(F+31), which is already beyond any output after scaling.
    always_comb begin
        n_st0       = '0;
        n_st0.zero  = r_zero;
        n_st0.sx    = r_pre4.sx;
        n_st0.sy    = r_pre4.sy;
        n_st0.pypos = r_pre4.pypos;
        n_st0.cneg  = r_cneg;
        n_st0.ksat  = (64'(r_cmag[63:31]) >= r_d4);
        n_st0.ax    = r_pre4.ax;
        n_st0.ay    = r_pre4.ay;
        n_st0.d     = r_d4;
        n_st0.cmag  = r_cmag;
        n_st0.rx    = 32'(r_pre4.ax[31:1]);
        n_st0.ry    = 32'(r_pre4.ay[31:1]);
        n_st0.prx   = 64'(r_pre4.ax[31:1]);
        n_st0.pry   = 64'(r_pre4.ay[31:1]);
        n_st0.krem  = 64'(r_cmag[63:31]);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_st[0] <= n_st0;
        end
    end

    // Iterative stages: one root bit, one quotient bit per divider per stage.
    for (genvar j = 0; j < NS; j++) begin : g_stage
        localparam int SI  = (j < 32) ? 31 - j : 0;
        localparam int KBI = (j <= 30) ? 30 - j : 0;

        always_comb begin
            logic [35:0] rem2;
            logic [35:0] trial;
            logic [32:0] dx2;
            logic [32:0] dy2;
            logic [32:0] rden;
            logic [64:0] px2;
            logic [64:0] py2;
            logic [64:0] k2;
            logic [64:0] dden;
            logic        kbit;

            n_st[j] = r_st[j];
            rem2    = {r_st[j].srem, r_st[j].d[2*SI +: 2]};
            trial   = {2'b00, r_st[j].root, 2'b01};
            rden    = {1'b0, r_st[j].root};
            dx2     = {r_st[j].rx, (j == 32) ? r_st[j].ax[0] : 1'b0};
            dy2     = {r_st[j].ry, (j == 32) ? r_st[j].ay[0] : 1'b0};
            dden    = {1'b0, r_st[j].d};
            px2     = {r_st[j].prx, (j == 0) ? r_st[j].ax[0] : 1'b0};
            py2     = {r_st[j].pry, (j == 0) ? r_st[j].ay[0] : 1'b0};
            kbit    = (j <= 30) ? r_st[j].cmag[KBI] : 1'b0;
            k2      = {r_st[j].krem, kbit};

            if (j < 32) begin
                if (rem2 >= trial) begin
                    n_st[j].srem = 34'(rem2 - trial);
                    n_st[j].root = {r_st[j].root[30:0], 1'b1};
                end else begin
                    n_st[j].srem = rem2[33:0];
                    n_st[j].root = {r_st[j].root[30:0], 1'b0};
                end
            end

            if (j >= 32) begin
                if (dx2 >= rden) begin
                    n_st[j].rx = 32'(dx2 - rden);
                    n_st[j].cx = {r_st[j].cx[F-1:0], 1'b1};
                end else begin
                    n_st[j].rx = dx2[31:0];
                    n_st[j].cx = {r_st[j].cx[F-1:0], 1'b0};
                end
                if (dy2 >= rden) begin
                    n_st[j].ry = 32'(dy2 - rden);
                    n_st[j].cy = {r_st[j].cy[F-1:0], 1'b1};
                end else begin
                    n_st[j].ry = dy2[31:0];
                    n_st[j].cy = {r_st[j].cy[F-1:0], 1'b0};
                end
            end

            if (j < 2*F + 1) begin
                if (px2 >= dden) begin
                    n_st[j].prx = 64'(px2 - dden);
                    n_st[j].qpx = {r_st[j].qpx[2*F-1:0], 1'b1};
                end else begin
                    n_st[j].prx = px2[63:0];
                    n_st[j].qpx = {r_st[j].qpx[2*F-1:0], 1'b0};
                end
                if (py2 >= dden) begin
                    n_st[j].pry = 64'(py2 - dden);
                    n_st[j].qpy = {r_st[j].qpy[2*F-1:0], 1'b1};
                end else begin
                    n_st[j].pry = py2[63:0];
                    n_st[j].qpy = {r_st[j].qpy[2*F-1:0], 1'b0};
                end
            end

            if (j < F + 31) begin
                if (k2 >= dden) begin
                    n_st[j].krem = 64'(k2 - dden);
                    n_st[j].kq   = {r_st[j].kq[F+29:0], 1'b1};
                end else begin
                    n_st[j].krem = k2[63:0];
                    n_st[j].kq   = {r_st[j].kq[F+29:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_st[j+1] <= n_st[j];
            end
        end
    end

    // First output stage: direction cosines and bearing terms are signed and
    // saturated here, and a near-zero range forces them to zero.
    always_comb begin
        w_qpx_ext = 64'(r_st[NS].qpx);
        w_qpy_ext = 64'(r_st[NS].qpy);
        w_magpx   = (w_qpx_ext >= 64'(MAG_CAP)) ? MAG_CAP : w_qpx_ext[31:0];
        w_magpy   = (w_qpy_ext >= 64'(MAG_CAP)) ? MAG_CAP : w_qpy_ext[31:0];
        if (r_st[NS].zero) begin
            n_m_drdx  = 32'd0;
            n_m_drdy  = 32'd0;
            n_m_dphix = 32'd0;
            n_m_dphiy = 32'd0;
        end else begin
            n_m_drdx  = sign_sat(32'(r_st[NS].cx), r_st[NS].sx);
            n_m_drdy  = sign_sat(32'(r_st[NS].cy), r_st[NS].sy);
            n_m_dphix = sign_sat(w_magpy, r_st[NS].pypos);
            n_m_dphiy = sign_sat(w_magpx, r_st[NS].sx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m_drdx  <= n_m_drdx;
            r_m_drdy  <= n_m_drdy;
            r_m_dphix <= n_m_dphix;
            r_m_dphiy <= n_m_dphiy;
            r_m_zero  <= r_st[NS].zero;
            r_o_drdx  <= r_m_drdx;
            r_o_drdy  <= r_m_drdy;
            r_o_dphix <= r_m_dphix;
            r_o_dphiy <= r_m_dphiy;
            r_o_zero  <= r_m_zero;
        end
    end

    // Range-rate terms: direction cosine times the scaled cross term.
    rmj_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul_x (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_ratio (r_st[NS].cy),
        .i_k     (r_st[NS].kq),
        .i_ksat  (r_st[NS].ksat),
        .i_neg   (r_st[NS].sy != r_st[NS].cneg),
        .i_zero  (r_st[NS].zero),
        .o_res   (w_rate_x)
    );

    rmj_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul_y (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_ratio (r_st[NS].cx),
        .i_k     (r_st[NS].kq),
        .i_ksat  (r_st[NS].ksat),
        .i_neg   (r_st[NS].sx == r_st[NS].cneg),
        .i_zero  (r_st[NS].zero),
        .o_res   (w_rate_y)
    );

    assign o_dr_dx      = r_o_drdx;
    assign o_dr_dy      = r_o_drdy;
    assign o_dphi_dx    = r_o_dphix;
    assign o_dphi_dy    = r_o_dphiy;
    assign o_drate_dx   = w_rate_x;
    assign o_drate_dy   = w_rate_y;
    assign o_range_zero = r_o_zero;

    `RMJ_ASSERT_NEXT(a_reset_empties, i_clk, !i_rst_n, !o_valid, "valid item after reset")

    `RMJ_ASSERT(a_zero_outputs, i_clk, i_rst_n, o_valid && o_range_zero,
        o_dr_dx == 0 && o_dr_dy == 0 && o_dphi_dx == 0 && o_dphi_dy == 0
        && o_drate_dx == 0 && o_drate_dy == 0,
        "near-zero range with nonzero entries")

    `RMJ_ASSERT(a_cosine_bound, i_clk, i_rst_n, o_valid && !o_range_zero,
        o_dr_dx <= ONE_Q && o_dr_dx >= -ONE_Q && o_dr_dy <= ONE_Q && o_dr_dy >= -ONE_Q,
        "direction cosine beyond one")

    `RMJ_ASSERT(a_bearing_sign, i_clk, i_rst_n,
        o_valid && !o_range_zero && !o_dr_dy[31] && o_dr_dy != 0,
        o_dphi_dx[31] || o_dphi_dx == 0, "bearing term has the wrong sign")

endmodule

// ===== hdl/rmj_mul.sv =====
module rmj_mul import rmj_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [FRAC_BITS:0]     i_ratio,
    input  logic [FRAC_BITS+30:0]  i_k,
    input  logic                   i_ksat,
    input  logic                   i_neg,
    input  logic                   i_zero,
    output logic [31:0]            o_res
);

    localparam int RW = FRAC_BITS + 1;
    localparam int KW = FRAC_BITS + 31;
    localparam int KL = KW / 2;
    localparam int KH = KW - KL;
    localparam int PW = RW + KW;

    logic [RW+KL-1:0] r_pl;
    logic [RW+KH-1:0] r_ph;
    logic             r_sat;
    logic             r_neg;
    logic             r_zero;
    logic [31:0]      r_res;

    logic [PW-1:0]    w_prod;
    logic [KW:0]      w_scaled;
    logic [31:0]      w_mag;
    logic [31:0]      n_res;

    // First stage: two partial products of the ratio with the halves of k.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pl   <= (RW+KL)'(i_ratio) * (RW+KL)'(i_k[KL-1:0]);
            r_ph   <= (RW+KH)'(i_ratio) * (RW+KH)'(i_k[KW-1:KL]);
            r_sat  <= i_ksat && (i_ratio != '0);
            r_neg  <= i_neg;
            r_zero <= i_zero;
        end
    end

    // Second stage: recombine, drop the fraction, cap and apply the sign.
    always_comb begin
        w_prod   = (PW'(r_ph) << KL) + PW'(r_pl);
        w_scaled = w_prod[PW-1:FRAC_BITS];
        w_mag    = (r_sat || (|w_scaled[KW:31])) ? MAG_CAP : w_scaled[31:0];
        n_res    = r_zero ? 32'd0 : sign_sat(w_mag, r_neg);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// ===== dv/radar_measurement_jacobian_checker.sv =====
`timescale 1ns / 100ps

module radar_measurement_jacobian_checker import rmj_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [30:0]        i_cfg_wr_data,
    input  logic               i_valid,
    input  logic               i_in_stall,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_dr_dx,
    input  logic signed [31:0] i_dr_dy,
    input  logic signed [31:0] i_dphi_dx,
    input  logic signed [31:0] i_dphi_dy,
    input  logic signed [31:0] i_drate_dx,
    input  logic signed [31:0] i_drate_dy,
    input  logic               i_range_zero,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int FB = FRAC_BITS_DEF;

    typedef struct packed {
        logic [31:0] dr_dx;
        logic [31:0] dr_dy;
        logic [31:0] dphi_dx;
        logic [31:0] dphi_dy;
        logic [31:0] drate_dx;
        logic [31:0] drate_dy;
        logic        range_zero;
    } t_jacobian;

    t_jacobian   jacobian_q[$];
    logic [30:0] threshold;

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // Long division of num * 2^sh by den, clamped at cap.
    function automatic logic [63:0] shifted_quotient(input logic [63:0] num, input int sh,
                                                      input logic [63:0] den,
                                                      input logic [63:0] cap);
        logic [64:0] rem;
        logic [63:0] q;
        q = num / den;
        rem = num % den;
        if (q >= cap) return cap;
        for (int i = 0; i < sh; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den) begin
                rem = rem - den;
                q = q + 1;
            end
            if (q >= cap) return cap;
        end
        return q;
    endfunction

    function automatic logic [63:0] scaled_product(input logic [63:0] ratio,
                                                   input logic [63:0] k);
        logic [127:0] p;
        if (ratio == 0 || k == 0) return 64'd0;
        p = ratio * k;
        if (p[127:64] != 0) return 64'd1 << 31;
        p = p >> FB;
        return (p > (128'd1 << 31)) ? (64'd1 << 31) : p[63:0];
    endfunction

    function automatic logic [31:0] apply_sign(input logic [63:0] mag, input logic neg);
        if (neg) return (mag >= (64'd1 << 31)) ? 32'h8000_0000 : 32'(-mag);
        return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    function automatic t_jacobian predict_jacobian(input logic signed [31:0] px,
                                                   input logic signed [31:0] py,
                                                   input logic signed [31:0] vx,
                                                   input logic signed [31:0] vy);
        t_jacobian          j;
        logic [63:0]        ax, ay, d, r, cx, cy, k, cmag;
        logic signed [63:0] t1, t2;
        logic               cneg;
        j = '0;
        ax = (px < 0) ? 64'(-64'(px)) : 64'(px);
        ay = (py < 0) ? 64'(-64'(py)) : 64'(py);
        d = ax * ax + ay * ay;
        if (d == 0 || d < ({33'd0, threshold} << FB)) begin
            j.range_zero = 1'b1;
            return j;
        end
        r = isqrt(d);
        cx = shifted_quotient(ax, FB, r, 64'd1 << 62);
        cy = shifted_quotient(ay, FB, r, 64'd1 << 62);
        t1 = 64'(vx) * 64'(py);
        t2 = 64'(vy) * 64'(px);
        cneg = t1 < t2;
        cmag = cneg ? 64'(t2 - t1) : 64'(t1 - t2);
        k = shifted_quotient(cmag, FB, d, 64'd1 << 62);
        j.dr_dx = apply_sign(cx, px < 0);
        j.dr_dy = apply_sign(cy, py < 0);
        j.dphi_dx = apply_sign(shifted_quotient(ay, 2 * FB, d, 64'd1 << 31), py > 0);
        j.dphi_dy = apply_sign(shifted_quotient(ax, 2 * FB, d, 64'd1 << 31), px < 0);
        j.drate_dx = apply_sign(scaled_product(cy, k), (py < 0) != cneg);
        j.drate_dy = apply_sign(scaled_product(cx, k), (px < 0) == cneg);
        return j;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;
    assign o_pending = jacobian_q.size();

    always @(posedge i_clk) begin
        t_jacobian want;
        if (!i_rst_n) begin
            threshold <= LIMIT_RESET;
        end else begin
            if (i_cfg_wr_en) threshold <= i_cfg_wr_data;
            if (i_valid && !i_in_stall)
                jacobian_q.push_back(predict_jacobian(i_pos_x, i_pos_y, i_vel_x, i_vel_y));
            if (i_out_valid && !i_out_stall) begin
                if (jacobian_q.size() == 0) begin
                    report_mismatch("result with nothing expected", 32'd1, 32'd0);
                end else begin
                    want = jacobian_q.pop_front();
                    if (i_dr_dx !== want.dr_dx) report_mismatch("dr_dx", i_dr_dx, want.dr_dx);
                    if (i_dr_dy !== want.dr_dy) report_mismatch("dr_dy", i_dr_dy, want.dr_dy);
                    if (i_dphi_dx !== want.dphi_dx)
                        report_mismatch("dphi_dx", i_dphi_dx, want.dphi_dx);
                    if (i_dphi_dy !== want.dphi_dy)
                        report_mismatch("dphi_dy", i_dphi_dy, want.dphi_dy);
                    if (i_drate_dx !== want.drate_dx)
                        report_mismatch("drate_dx", i_drate_dx, want.drate_dx);
                    if (i_drate_dy !== want.drate_dy)
                        report_mismatch("drate_dy", i_drate_dy, want.drate_dy);
                    if (i_range_zero !== want.range_zero)
                        report_mismatch("range_zero", 32'(i_range_zero), 32'(want.range_zero));
                end
            end
        end
    end

endmodule

// ===== dv/tb_radar_measurement_jacobian_core.sv =====
`timescale 1ns / 100ps

module tb_radar_measurement_jacobian_core;
    import rmj_pkg::*;

    // The pipeline is FRAC_BITS + 40 stages deep.
    localparam int LATENCY = FRAC_BITS_DEF + 40;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [30:0]        cfg_wr_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] dr_dx, dr_dy, dphi_dx, dphi_dy, drate_dx, drate_dy;
    logic               range_zero;
    int                 fail_count;
    int                 pending;
    // Set once the final stretch begins, where neither side idles.
    logic               quiet_tail;
    // Requests a long receiver hold-off so that the pipeline fills.
    logic               hold_request;

    always begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    radar_measurement_jacobian_core u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_valid       (in_valid),
        .o_stall       (in_stall),
        .i_pos_x       (pos_x),
        .i_pos_y       (pos_y),
        .i_vel_x       (vel_x),
        .i_vel_y       (vel_y),
        .o_valid       (out_valid),
        .i_stall       (out_stall),
        .o_dr_dx       (dr_dx),
        .o_dr_dy       (dr_dy),
        .o_dphi_dx     (dphi_dx),
        .o_dphi_dy     (dphi_dy),
        .o_drate_dx    (drate_dx),
        .o_drate_dy    (drate_dy),
        .o_range_zero  (range_zero)
    );

    radar_measurement_jacobian_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_valid       (in_valid),
        .i_in_stall    (in_stall),
        .i_pos_x       (pos_x),
        .i_pos_y       (pos_y),
        .i_vel_x       (vel_x),
        .i_vel_y       (vel_y),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_dr_dx       (dr_dx),
        .i_dr_dy       (dr_dy),
        .i_dphi_dx     (dphi_dx),
        .i_dphi_dy     (dphi_dy),
        .i_drate_dx    (drate_dx),
        .i_drate_dy    (drate_dy),
        .i_range_zero  (range_zero),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Random extreme-biased field value: corners, small values near zero,
    // moderate ranges and fully random words.
    function automatic logic [31:0] pick_field();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 16)) - 8);
            3: return 32'($signed($urandom_range(0, 1024)) - 512);
            4, 5: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
            6: return 32'($signed($urandom_range(0, 32'h0001_FFFF)) - 32'sh0001_0000);
            default: return $urandom;
        endcase
    endfunction

    // Offers one item and holds it until the block takes it. Random idle gaps
    // are inserted before the offer, except in the final stretch.
    task automatic send_item(input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] vx, input logic [31:0] vy);
        int gap;
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pos_x <= px;
        pos_y <= py;
        vel_x <= vx;
        vel_y <= vy;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Waits until every expected result has arrived and the pipeline has drained.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [30:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Receiver side: random stall bursts, plus one long hold-off on request.
    initial begin
        int burst;
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                out_stall <= 1'b1;
                repeat (3 * LATENCY) @(posedge clk);
                out_stall <= 1'b0;
                wait (!hold_request);
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 10);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        #50ms;
        $display("tb_radar_measurement_jacobian_core NOT OK");
        $finish;
    end

    initial begin
        logic [30:0] settings[4];
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        pos_x = '0;
        pos_y = '0;
        vel_x = '0;
        vel_y = '0;
        quiet_tail = 1'b0;
        hold_request = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items with the reset threshold: origin, a point below the
        // threshold, points above it, full-scale corners and each axis alone.
        send_item(0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(1, 0, 5, 5);
        send_item(0, 32'h0002_0000, 32'h0001_0000, 0);
        send_item(32'h0002_9E00, 0, 0, 32'h0001_0000);
        send_item(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_item(32'h0000_0100, 32'hFFFF_FF00, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(32'hFFFF_FFFF, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'hFFFF_0000);
        send_item(32'hFFFD_0000, 32'hFFFC_0000, 32'hFFFF_0000, 32'h0001_0000);
        send_item(32'h0000_0010, 32'h0000_0010, 32'h7FFF_FFFF, 32'h8000_0000);
        drain();

        // Zero threshold: only the origin counts as near zero.
        write_threshold(31'd0);
        send_item(0, 0, 1, 1);
        send_item(1, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        send_item(1, 1, 32'h8000_0000, 32'h7FFF_FFFF);
        drain();

        // Largest threshold: near zero means a squared range below (2^31 - 1) * 2^16.
        write_threshold(31'h7FFF_FFFF);
        send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 2);
        send_item(32'h8000_0000, 32'h8000_0000, 1, 2);
        send_item(32'h7FFF_FFFF, 0, 1, 2);
        send_item(32'h0100_0000, 32'h0100_0000, 1, 2);
        drain();

        // Random phases, each under its own threshold. The last setting is
        // the reset value; one phase includes a long receiver hold-off.
        settings[0] = 31'd0;
        settings[1] = 31'($urandom_range(1, 1000));
        settings[2] = 31'($urandom_range(0, 32'h00FF_FFFF));
        settings[3] = LIMIT_RESET;
        for (int ph = 0; ph < 4; ph++) begin
            write_threshold(settings[ph]);
            if (ph == 3) quiet_tail = 1'b1;
            for (int n = 0; n < 450; n++) begin
                if (ph == 1 && n == 100) hold_request <= 1'b1;
                if (ph == 1 && n == 200) hold_request <= 1'b0;
                send_item(pick_field(), pick_field(), pick_field(), pick_field());
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("tb_radar_measurement_jacobian_core OK");
        end else begin
            $display("tb_radar_measurement_jacobian_core NOT OK");
        end
        $finish;
    end

endmodule
